/* design/assert_macros.svh */
// assertion macro for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CCIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

/* design/ccit_pkg.sv */
// package for the circle impact time pipeline: widths, codes and stage types
`default_nettype none
package ccit_pkg;
    localparam int FRAC_BITS = 24;
    localparam int DW        = 33;                 // difference width
    localparam int AW        = 66;                 // |dv|^2 and |b| width
    localparam int HW        = 136;                // discriminant width
    localparam int XW        = HW + 2 * FRAC_BITS; // radicand width
    localparam int SQ_STEPS  = XW / 2;             // root bits
    localparam int RW        = SQ_STEPS + 4;       // partial remainder width
    localparam int QW        = 31;                 // time width
    localparam int NW        = AW + QW;            // dividend width

    typedef enum logic [2:0] {
        ST_HIT  = 3'd0,
        ST_GONE = 3'd1,
        ST_SLOW = 3'd2,
        ST_SEP  = 3'd3,
        ST_MISS = 3'd4,
        ST_SOON = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        REG_MIN_SPEED = 1'b0,
        REG_MIN_TIME  = 1'b1
    } t_reg;

    typedef struct packed {
        logic [XW-1:0]       x;
        logic [RW-1:0]       rem;
        logic [SQ_STEPS-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [NW-1:0] d;
        logic [QW-1:0] q;
    } t_dv;
endpackage
`default_nettype wire

/* design/ccit_sqrt_step.sv */
// one digit of the restoring square root
`default_nettype none
module ccit_sqrt_step import ccit_pkg::*; (
    input  t_sq i_cur,
    output t_sq o_nxt
);
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;

    always_comb begin
        cur   = {i_cur.rem[RW-3:0], i_cur.x[XW-1 -: 2]};
        trial = {{(RW-SQ_STEPS-2){1'b0}}, i_cur.root, 2'b01};
        o_nxt.x = {i_cur.x[XW-3:0], 2'b00};
        if (cur >= trial) begin
            o_nxt.rem  = cur - trial;
            o_nxt.root = {i_cur.root[SQ_STEPS-2:0], 1'b1};
        end else begin
            o_nxt.rem  = cur;
            o_nxt.root = {i_cur.root[SQ_STEPS-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

/* design/ccit_div_step.sv */
// one quotient bit of the restoring divider
`default_nettype none
module ccit_div_step import ccit_pkg::*; (
    input  t_dv i_cur,
    output t_dv o_nxt
);
    always_comb begin
        o_nxt.d = {1'b0, i_cur.d[NW-1:1]};
        if (i_cur.rem >= i_cur.d) begin
            o_nxt.rem = i_cur.rem - i_cur.d;
            o_nxt.q   = {i_cur.q[QW-2:0], 1'b1};
        end else begin
            o_nxt.rem = i_cur.rem;
            o_nxt.q   = {i_cur.q[QW-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

/* design/circle_circle_impact_time_top.sv */
// top level of the swept circle-circle time of impact pipeline
// throughput: one request per cycle; the whole pipe holds when the result is stalled
// the square root takes one root bit per stage and the divider one time bit per stage
// reset clears the stage valid bits and loads min_speed_sq = 281, min_time = 1
`default_nettype none
module circle_circle_impact_time_top import ccit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_a_pos_x,
    input  logic [31:0] i_a_pos_y,
    input  logic [31:0] i_a_vel_x,
    input  logic [31:0] i_a_vel_y,
    input  logic [31:0] i_b_pos_x,
    input  logic [31:0] i_b_pos_y,
    input  logic [31:0] i_b_vel_x,
    input  logic [31:0] i_b_vel_y,
    input  logic [23:0] i_a_radius,
    input  logic [23:0] i_b_radius,
    input  logic        i_a_gone,
    input  logic        i_b_gone,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [30:0] o_impact_time,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    `include "assert_macros.svh"

    // stage map: 0 diffs, 1 products, 2 sums, 3 split products, 4 b^2 and |A*C|,
    // 5 discriminant, 6..97 root, 98 numerator, 99..129 divide, 130 result
    localparam int SQ0 = 6;
    localparam int NUM = SQ0 + SQ_STEPS;
    localparam int DV0 = NUM + 1;
    localparam int LAT = DV0 + QW + 1;

    // configuration registers
    logic [31:0] r_min_speed;
    logic [23:0] r_min_time;
    t_reg        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= 32'd281;
            r_min_time  <= 24'd1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_MIN_SPEED: r_min_speed <= pwdata;
                REG_MIN_TIME:  r_min_time  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MIN_SPEED: prdata = r_min_speed;
            REG_MIN_TIME:  prdata = {8'd0, r_min_time};
            default:       prdata = '0;
        endcase
    end

    // global stall: everything moves unless the result register is held
    logic           ce;
    logic [LAT-1:0] r_vld;

    assign ce      = !r_vld[LAT-1] || i_ready;
    assign o_ready = ce;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage 0: relative position, velocity and summed radius
    logic signed [DW-1:0] r_dx, r_dy, r_dvx, r_dvy;
    logic [24:0]          r_rs;
    logic                 r_gone0;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dx    <= {i_b_pos_x[31], i_b_pos_x} - {i_a_pos_x[31], i_a_pos_x};
            r_dy    <= {i_b_pos_y[31], i_b_pos_y} - {i_a_pos_y[31], i_a_pos_y};
            r_dvx   <= {i_b_vel_x[31], i_b_vel_x} - {i_a_vel_x[31], i_a_vel_x};
            r_dvy   <= {i_b_vel_y[31], i_b_vel_y} - {i_a_vel_y[31], i_a_vel_y};
            r_rs    <= {1'b0, i_a_radius} + {1'b0, i_b_radius};
            r_gone0 <= i_a_gone || i_b_gone;
        end
    end

    // stage 1: the seven scalar products
    logic signed [2*DW-1:0] r_pvx, r_pvy, r_pxv, r_pyv, r_pxx, r_pyy;
    logic [49:0]            r_prr;
    logic                   r_gone1;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pvx   <= r_dvx * r_dvx;
            r_pvy   <= r_dvy * r_dvy;
            r_pxv   <= r_dx * r_dvx;
            r_pyv   <= r_dy * r_dvy;
            r_pxx   <= r_dx * r_dx;
            r_pyy   <= r_dy * r_dy;
            r_prr   <= r_rs * r_rs;
            r_gone1 <= r_gone0;
        end
    end

    // stage 2: quadratic coefficients, b is half of B
    logic [AW-1:0]        r_a2;
    logic signed [AW:0]   r_b2;
    logic signed [AW:0]   r_c2;
    logic                 r_gone2;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a2    <= AW'(r_pvx) + AW'(r_pvy);
            r_b2    <= {r_pxv[2*DW-1], r_pxv} + {r_pyv[2*DW-1], r_pyv};
            r_c2    <= {r_pxx[2*DW-1], r_pxx} + {r_pyy[2*DW-1], r_pyy}
                       - (AW+1)'({1'b0, r_prr});
            r_gone2 <= r_gone1;
        end
    end

    // stage 3: early rejects and split products for b^2 and A*C
    localparam int HB = AW / 2;
    logic [AW-1:0]   b_mag, c_mag;
    t_status         st3;
    logic [2*HB-1:0] r_bhh, r_bhl, r_bll, r_ahh, r_ahl, r_alh, r_all;
    logic            r_cneg3;
    logic [AW-1:0]   r_a3, r_nb3;
    t_status         r_st3;

    always_comb begin
        b_mag = r_b2[AW] ? AW'(-r_b2) : AW'(r_b2);
        c_mag = r_c2[AW] ? AW'(-r_c2) : AW'(r_c2);
        if (r_gone2) begin
            st3 = ST_GONE;
        end else if (r_a2 < AW'(r_min_speed)) begin
            st3 = ST_SLOW;
        end else if (!r_b2[AW]) begin
            st3 = ST_SEP;
        end else begin
            st3 = ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_bhh   <= b_mag[AW-1:HB] * b_mag[AW-1:HB];
            r_bhl   <= b_mag[AW-1:HB] * b_mag[HB-1:0];
            r_bll   <= b_mag[HB-1:0]  * b_mag[HB-1:0];
            r_ahh   <= r_a2[AW-1:HB]  * c_mag[AW-1:HB];
            r_ahl   <= r_a2[AW-1:HB]  * c_mag[HB-1:0];
            r_alh   <= r_a2[HB-1:0]   * c_mag[AW-1:HB];
            r_all   <= r_a2[HB-1:0]   * c_mag[HB-1:0];
            r_cneg3 <= r_c2[AW];
            r_a3    <= r_a2;
            r_nb3   <= b_mag;
            r_st3   <= st3;
        end
    end

    // stage 4: assemble b^2 and |A*C|
    logic [2*AW-1:0] r_bsq, r_acm;
    logic            r_cneg4;
    logic [AW-1:0]   r_a4, r_nb4;
    t_status         r_st4;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_bsq   <= ((2*AW)'(r_bhh) << (2*HB)) + ((2*AW)'(r_bhl) << (HB+1))
                       + (2*AW)'(r_bll);
            r_acm   <= ((2*AW)'(r_ahh) << (2*HB))
                       + (((2*AW)'(r_ahl) + (2*AW)'(r_alh)) << HB) + (2*AW)'(r_all);
            r_cneg4 <= r_cneg3;
            r_a4    <= r_a3;
            r_nb4   <= r_nb3;
            r_st4   <= r_st3;
        end
    end

    // stage 5: discriminant / 4, miss when negative
    logic [HW-1:0] h;
    t_status       st5;
    t_sq           r_sq5;
    logic [AW-1:0] r_a5, r_nb5;
    t_status       r_st5;

    always_comb begin
        h = r_cneg4 ? HW'(r_bsq) + HW'(r_acm) : HW'(r_bsq) - HW'(r_acm);
        st5 = r_st4;
        if (r_st4 == ST_HIT && h[HW-1]) begin
            st5 = ST_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sq5.x    <= {h, {(2*FRAC_BITS){1'b0}}};
            r_sq5.rem  <= '0;
            r_sq5.root <= '0;
            r_a5       <= r_a4;
            r_nb5      <= r_nb4;
            r_st5      <= st5;
        end
    end

    // root stages: one bit of sqrt(h << 2*FRAC_BITS) per stage
    t_sq           r_sq [SQ_STEPS];
    logic [AW-1:0] r_sqa [SQ_STEPS];
    logic [AW-1:0] r_sqn [SQ_STEPS];
    t_status       r_sqs [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        t_sq sq_in, sq_out;
        if (k == 0) begin : g_first
            assign sq_in = r_sq5;
        end else begin : g_rest
            assign sq_in = r_sq[k-1];
        end
        ccit_sqrt_step u_step (.i_cur(sq_in), .o_nxt(sq_out));
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_sq[k]  <= sq_out;
                r_sqa[k] <= (k == 0) ? r_a5  : r_sqa[k-1 + (k == 0)];
                r_sqn[k] <= (k == 0) ? r_nb5 : r_sqn[k-1 + (k == 0)];
                r_sqs[k] <= (k == 0) ? r_st5 : r_sqs[k-1 + (k == 0)];
            end
        end
    end

    // numerator stage: num = (-b << FRAC_BITS) - ceil(sqrt), saturation check
    localparam int NUMW = SQ_STEPS + 3;
    logic [SQ_STEPS:0] s_ceil;
    logic [NUMW-1:0]   num;
    t_status           st_n;
    t_dv               r_dvn;
    logic              r_satn;
    t_status           r_stn;

    always_comb begin
        s_ceil = {1'b0, r_sq[SQ_STEPS-1].root}
                 + (SQ_STEPS+1)'(r_sq[SQ_STEPS-1].rem != '0);
        num    = NUMW'({r_sqn[SQ_STEPS-1], {FRAC_BITS{1'b0}}}) - NUMW'(s_ceil);
        st_n   = r_sqs[SQ_STEPS-1];
        if (st_n == ST_HIT && num[NUMW-1]) begin
            st_n = ST_SOON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dvn.rem <= NW'(num);
            r_dvn.d   <= NW'({r_sqa[SQ_STEPS-1], {(QW-1){1'b0}}});
            r_dvn.q   <= '0;
            r_satn    <= NW'(num) >= {r_sqa[SQ_STEPS-1], {QW{1'b0}}};
            r_stn     <= st_n;
        end
    end

    // divide stages: one time bit per stage, most significant first
    t_dv     r_dv  [QW];
    logic    r_dvsat [QW];
    t_status r_dvs [QW];

    for (genvar k = 0; k < QW; k++) begin : g_dv
        t_dv dv_in, dv_out;
        if (k == 0) begin : g_first
            assign dv_in = r_dvn;
        end else begin : g_rest
            assign dv_in = r_dv[k-1];
        end
        ccit_div_step u_step (.i_cur(dv_in), .o_nxt(dv_out));
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dv[k]    <= dv_out;
                r_dvsat[k] <= (k == 0) ? r_satn : r_dvsat[k-1 + (k == 0)];
                r_dvs[k]   <= (k == 0) ? r_stn  : r_dvs[k-1 + (k == 0)];
            end
        end
    end

    // result stage: saturate, apply the minimum time, zero the time on a reject
    logic [QW-1:0] t_fin;
    t_status       st_f;

    always_comb begin
        t_fin = r_dvsat[QW-1] ? {QW{1'b1}} : r_dv[QW-1].q;
        st_f  = r_dvs[QW-1];
        if (st_f == ST_HIT && t_fin < QW'(r_min_time)) begin
            st_f = ST_SOON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_hit         <= (st_f == ST_HIT);
            o_impact_time <= (st_f == ST_HIT) ? t_fin : '0;
            o_status      <= st_f;
        end
    end

    // checks
    `CCIT_ASSERT(a_hit_code, o_valid |-> (o_hit == (o_status == ST_HIT)), "hit and status disagree")
    `CCIT_ASSERT(a_miss_zero, (o_valid && !o_hit) |-> (o_impact_time == '0), "time on a reject")
    `CCIT_ASSERT(a_hit_min, (o_valid && o_hit) |-> (o_impact_time >= QW'(r_min_time)), "hit below min")
    `CCIT_ASSERT(a_hold, !ce |=> $stable(r_vld), "valid bits moved during a stall")
endmodule
`default_nettype wire
